@@ hdl/swde_pkg.sv @@
// shared types and constants for the single-wire dimming encoder
// used by swde_seq and single_wire_dimming_encoder; no dependencies
`default_nettype none

package swde_pkg;

    localparam int LEVEL_W = 8;
    localparam int DUR_W   = 12;
    localparam int DATA_W  = 5;

    localparam logic [DUR_W-1:0] DUR_BIT_LONG    = 12'd67;
    localparam logic [DUR_W-1:0] DUR_BIT_SHORT   = 12'd33;
    localparam logic [DUR_W-1:0] DUR_SEP         = 12'd4;
    localparam logic [DUR_W-1:0] DUR_WAKE_OFF    = 12'd4000;
    localparam logic [DUR_W-1:0] DUR_WAKE_HIGH   = 12'd190;
    localparam logic [DUR_W-1:0] DUR_WAKE_DETECT = 12'd286;
    localparam logic [DUR_W-1:0] DUR_WAKE_WINDOW = 12'd1000;
    localparam logic [DUR_W-1:0] DUR_HOLD        = 12'd0;

    localparam logic [7:0] ADDR_RESET = 8'h72;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_START_AWAKE    = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             pin;
        logic [DUR_W-1:0] dur;
        logic             last;
    } t_seg;

endpackage

`default_nettype wire

@@ hdl/single_wire_dimming_encoder.sv @@
// top level of the single-wire dimming encoder: config registers, line state,
// input handshake and output register; uses swde_pkg and swde_seq
//
// Each accepted level produces a run of pin segments on the output stream,
// one segment per cycle while the output is not stalled: 1 segment for level
// zero, 36 for a nonzero level, 40 when the wake sequence goes first. The
// segment sequencer steps once per segment and accepts the next level only
// after the final segment has advanced into the output register; that register
// lets a new level be taken while the final segment still waits downstream.
`default_nettype none

module single_wire_dimming_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] level
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [0] pin_level, [12:1] duration_us
    output logic             o_m_axis_tlast
);

    logic [7:0]                 r_dev_addr;
    logic                       r_start_awake;
    logic                       r_awake;
    logic                       r_touched;

    logic                       r_out_valid;
    logic                       r_out_pin;
    logic [swde_pkg::DUR_W-1:0] r_out_dur;
    logic                       r_out_last;

    swde_pkg::t_seg             w_seg;
    logic                       w_idle;
    logic                       w_in_xfer;
    logic                       w_adv;
    logic                       w_eff_awake;

    assign o_s_axis_tready = w_idle;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_adv           = w_seg.valid && (!r_out_valid || i_m_axis_tready);
    assign w_eff_awake     = r_touched ? r_awake : r_start_awake;

    swde_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_xfer),
        .i_level     (i_s_axis_tdata),
        .i_addr      (r_dev_addr),
        .i_eff_awake (w_eff_awake),
        .i_adv       (w_adv),
        .o_seg       (w_seg),
        .o_idle      (w_idle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= swde_pkg::ADDR_RESET;
            r_start_awake <= 1'b0;
            r_awake       <= 1'b0;
            r_touched     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    swde_pkg::REG_DEVICE_ADDRESS: r_dev_addr    <= i_cfg_data;
                    swde_pkg::REG_START_AWAKE:    r_start_awake <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_in_xfer) begin
                r_touched <= 1'b1;
                r_awake   <= (i_s_axis_tdata != 8'd0);
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out_pin  <= w_seg.pin;
            r_out_dur  <= w_seg.dur;
            r_out_last <= w_seg.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_dur, r_out_pin};
    assign o_m_axis_tlast  = r_out_last;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_axis_tready)
        else $error("ready after level transfer");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_seg.last) |=> o_s_axis_tready)
        else $error("sequencer busy after final segment");

    a_no_seg_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_seg.valid)
        else $error("segment pending while ready");

endmodule

`default_nettype wire

@@ hdl/swde_seq.sv @@
// segment sequencer: walks wake, address byte, separators and data byte, or a single
// hold segment for a zero level, one segment per advance using a shared bit shifter; uses swde_pkg
`default_nettype none

module swde_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [swde_pkg::LEVEL_W-1:0] i_level,
    input  wire logic [7:0]                   i_addr,
    input  wire logic                         i_eff_awake,
    input  wire logic                         i_adv,
    output swde_pkg::t_seg                    o_seg,
    output logic                              o_idle
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ZERO = 3'd1;
    localparam logic [2:0] S_WAKE = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_SEP1 = 3'd4;
    localparam logic [2:0] S_DATA = 3'd5;
    localparam logic [2:0] S_SEP2 = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [3:0]                   r_cnt, n_cnt;
    logic [7:0]                   r_shift, n_shift;
    logic [swde_pkg::DATA_W-1:0]  r_data, n_data;

    logic [swde_pkg::DUR_W-1:0]   w_wake_dur;
    logic [swde_pkg::DUR_W-1:0]   w_bit_dur;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_wake_dur = swde_pkg::DUR_WAKE_OFF;
            2'd1:    w_wake_dur = swde_pkg::DUR_WAKE_HIGH;
            2'd2:    w_wake_dur = swde_pkg::DUR_WAKE_DETECT;
            default: w_wake_dur = swde_pkg::DUR_WAKE_WINDOW;
        endcase
    end

    // low half is long for a 0, high half is long for a 1
    assign w_bit_dur = (r_shift[7] == r_cnt[0]) ? swde_pkg::DUR_BIT_LONG
                                                : swde_pkg::DUR_BIT_SHORT;

    always_comb begin
        o_seg.valid = 1'b1;
        o_seg.pin   = r_cnt[0];
        o_seg.dur   = swde_pkg::DUR_SEP;
        o_seg.last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_seg.valid = 1'b0;
                o_seg.pin   = 1'b0;
                o_seg.dur   = swde_pkg::DUR_HOLD;
            end
            S_ZERO: begin
                o_seg.pin  = 1'b0;
                o_seg.dur  = swde_pkg::DUR_HOLD;
                o_seg.last = 1'b1;
            end
            S_WAKE: o_seg.dur = w_wake_dur;
            S_ADDR, S_DATA: o_seg.dur = w_bit_dur;
            S_SEP1: o_seg.dur = swde_pkg::DUR_SEP;
            S_SEP2: o_seg.last = r_cnt[0];
            default: o_seg.valid = 1'b0;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_data  = r_data;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cnt   = 4'd0;
                    n_shift = i_addr;
                    n_data  = i_level[swde_pkg::DATA_W-1:0];
                    if (i_level == '0) begin
                        n_state = S_ZERO;
                    end else if (!i_eff_awake) begin
                        n_state = S_WAKE;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ZERO: begin
                if (i_adv) n_state = S_IDLE;
            end
            S_WAKE: begin
                if (i_adv) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd3) begin
                        n_cnt   = 4'd0;
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR, S_DATA: begin
                if (i_adv) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt[0]) n_shift = {r_shift[6:0], 1'b0};
                    if (r_cnt == 4'd15) begin
                        n_state = (r_state == S_ADDR) ? S_SEP1 : S_SEP2;
                    end
                end
            end
            S_SEP1: begin
                if (i_adv) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt[0]) begin
                        n_cnt   = 4'd0;
                        n_shift = {{(8-swde_pkg::DATA_W){1'b0}}, r_data};
                        n_state = S_DATA;
                    end
                end
            end
            S_SEP2: begin
                if (i_adv) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt[0]) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_shift <= n_shift;
        r_data  <= n_data;
    end

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_start)
        else $error("start while busy");

    a_wake_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAKE) |-> (r_cnt < 4'd4))
        else $error("wake count overrun");

    a_sep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEP1 || r_state == S_SEP2) |-> (r_cnt < 4'd2))
        else $error("separator count overrun");

endmodule

`default_nettype wire

@@ tb/single_wire_dimming_encoder_tb.sv @@
// self-checking testbench for single_wire_dimming_encoder: directed table then random levels,
// every segment compared against an in-bench predictor of the pin sequence
// depends on swde_pkg and the single_wire_dimming_encoder rtl
module single_wire_dimming_encoder_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int CFG_SETTLE   = 4;
    localparam int PHASE_ITEMS  = 88;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic                       pin;
        logic [swde_pkg::DUR_W-1:0] dur;
        logic                       last;
    } t_seg_exp;

    typedef enum logic {ROW_LEVEL, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic       cfg_idx;
        logic [7:0] val;
        int         seg_cnt;
        int         first_dur;
    } t_dir_row;

    typedef struct {
        int seg_cnt;
        int first_dur;
    } t_item_note;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // line model
    logic [7:0] mdl_addr        = swde_pkg::ADDR_RESET;
    logic       mdl_start_awake = 1'b0;
    logic       mdl_awake       = 1'b0;
    logic       mdl_touched     = 1'b0;

    t_seg_exp   pending_segs[$];
    t_item_note item_notes[$];
    t_dir_row   dir_rows[$];

    int drv_seg_cnt   = 0;
    int drv_first_dur = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rx_hold_req   = 0;
    int rx_hold_left  = 0;
    int out_seg_idx   = 0;
    int mismatch_cnt  = 0;
    int segs_checked  = 0;
    int levels_sent   = 0;
    int cfg_writes    = 0;
    int cycle_cnt     = 0;

    single_wire_dimming_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] level
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [0] pin_level, [12:1] duration_us
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_mismatch(string what, logic [15:0] want_v,
                                          logic [15:0] got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("segment %0d: %s expected %0h got %0h", segs_checked, what, want_v, got_v);
        end
    endfunction

    function automatic void queue_seg(logic pin, logic [swde_pkg::DUR_W-1:0] dur, logic last);
        t_seg_exp s;
        s.pin  = pin;
        s.dur  = dur;
        s.last = last;
        pending_segs.push_back(s);
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) begin
                queue_seg(1'b0, swde_pkg::DUR_BIT_SHORT, 1'b0);
                queue_seg(1'b1, swde_pkg::DUR_BIT_LONG, 1'b0);
            end else begin
                queue_seg(1'b0, swde_pkg::DUR_BIT_LONG, 1'b0);
                queue_seg(1'b1, swde_pkg::DUR_BIT_SHORT, 1'b0);
            end
        end
    endfunction

    function automatic void predict_segments(logic [7:0] lvl);
        logic was_awake;
        was_awake   = mdl_touched ? mdl_awake : mdl_start_awake;
        mdl_touched = 1'b1;
        if (lvl == 8'd0) begin
            mdl_awake = 1'b0;
            queue_seg(1'b0, swde_pkg::DUR_HOLD, 1'b1);
            return;
        end
        if (!was_awake) begin
            queue_seg(1'b0, swde_pkg::DUR_WAKE_OFF, 1'b0);
            queue_seg(1'b1, swde_pkg::DUR_WAKE_HIGH, 1'b0);
            queue_seg(1'b0, swde_pkg::DUR_WAKE_DETECT, 1'b0);
            queue_seg(1'b1, swde_pkg::DUR_WAKE_WINDOW, 1'b0);
        end
        mdl_awake = 1'b1;
        queue_byte(mdl_addr);
        queue_seg(1'b0, swde_pkg::DUR_SEP, 1'b0);
        queue_seg(1'b1, swde_pkg::DUR_SEP, 1'b0);
        queue_byte({3'b000, lvl[swde_pkg::DATA_W-1:0]});
        queue_seg(1'b0, swde_pkg::DUR_SEP, 1'b0);
        queue_seg(1'b1, swde_pkg::DUR_SEP, 1'b1);
    endfunction

    function automatic void add_row(t_row_kind k, logic idx, logic [7:0] v, int cnt, int dur);
        t_dir_row r;
        r.kind      = k;
        r.cfg_idx   = idx;
        r.val       = v;
        r.seg_cnt   = cnt;
        r.first_dur = dur;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] random_level();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 8'd0;
        if (r < 60) return 8'($urandom_range(31, 1));
        return 8'($urandom_range(255));
    endfunction

    task automatic wait_drained();
        while (pending_segs.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (CFG_SETTLE) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        cfg_writes++;
    endtask

    task automatic send_level(logic [7:0] lvl, int cnt, int dur);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid      = 1'b1;
        s_tdata       = lvl;
        drv_seg_cnt   = cnt;
        drv_first_dur = dur;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            m_tready = 1'b0;
            rx_hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_seg_exp   want;
        t_item_note note;
        if (!i_rst_n) begin
            mdl_addr        = swde_pkg::ADDR_RESET;
            mdl_start_awake = 1'b0;
            mdl_awake       = 1'b0;
            mdl_touched     = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    swde_pkg::REG_DEVICE_ADDRESS: mdl_addr = cfg_data;
                    swde_pkg::REG_START_AWAKE:    mdl_start_awake = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pending_segs.size() == 0) begin
                    note_mismatch("segment with nothing pending", 16'h0, m_tdata);
                end else begin
                    want = pending_segs.pop_front();
                    if (m_tdata[0] !== want.pin)
                        note_mismatch("pin_level", 16'(want.pin), 16'(m_tdata[0]));
                    if (m_tdata[12:1] !== want.dur)
                        note_mismatch("duration_us", 16'(want.dur), 16'(m_tdata[12:1]));
                    if (m_tlast !== want.last)
                        note_mismatch("tlast", 16'(want.last), 16'(m_tlast));
                    if (m_tdata[15:13] !== 3'b000)
                        note_mismatch("tdata padding", 16'h0, 16'(m_tdata[15:13]));
                    if (item_notes.size() != 0) begin
                        note = item_notes[0];
                        if (note.seg_cnt != 0 && out_seg_idx == 0 &&
                            m_tdata[12:1] !== note.first_dur)
                            note_mismatch("first duration", 16'(note.first_dur),
                                          16'(m_tdata[12:1]));
                        if (want.last) begin
                            if (note.seg_cnt != 0 && out_seg_idx + 1 != note.seg_cnt)
                                note_mismatch("segment count", 16'(note.seg_cnt),
                                              16'(out_seg_idx + 1));
                            void'(item_notes.pop_front());
                            out_seg_idx = 0;
                        end else begin
                            out_seg_idx++;
                        end
                    end
                    segs_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_segments(s_tdata);
                note.seg_cnt   = drv_seg_cnt;
                note.first_dur = drv_first_dur;
                item_notes.push_back(note);
                levels_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d segments outstanding",
                     cycle_cnt, pending_segs.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] addr_sel;
        // start_awake set first so the opening level skips the wake sequence
        add_row(ROW_CFG,   swde_pkg::REG_START_AWAKE,    8'h01, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h10, 36, 67);
        add_row(ROW_CFG,   swde_pkg::REG_START_AWAKE,    8'h00, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h1F, 36, 67);
        add_row(ROW_CFG,   swde_pkg::REG_DEVICE_ADDRESS, 8'hFF, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h00, 1, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h20, 40, 4000);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'hFF, 36, 33);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h00, 1, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h00, 1, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h01, 40, 4000);
        add_row(ROW_CFG,   swde_pkg::REG_DEVICE_ADDRESS, 8'h00, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h80, 36, 67);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'hAA, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h55, 0, 0);
        add_row(ROW_CFG,   swde_pkg::REG_START_AWAKE,    8'hFF, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h00, 1, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h40, 40, 4000);
        add_row(ROW_CFG,   swde_pkg::REG_START_AWAKE,    8'hFE, 0, 0);
        add_row(ROW_CFG,   swde_pkg::REG_DEVICE_ADDRESS, 8'h72, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'h0A, 0, 0);
        add_row(ROW_LEVEL, swde_pkg::REG_DEVICE_ADDRESS, 8'hE0, 0, 0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].val);
            else
                send_level(dir_rows[i].val, dir_rows[i].seg_cnt, dir_rows[i].first_dur);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  addr_sel = 8'hFF; end
                1: begin tx_idle_pct = 72; rx_stall_pct = 0;  addr_sel = 8'h00; end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 72; addr_sel = 8'($urandom_range(255)); end
                default: begin
                    tx_idle_pct = 7; rx_stall_pct = 7; addr_sel = 8'($urandom_range(255));
                end
            endcase
            write_reg(swde_pkg::REG_DEVICE_ADDRESS, addr_sel);
            write_reg(swde_pkg::REG_START_AWAKE, 8'($urandom_range(255)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long downstream stall while levels keep coming
                if (ph == 0 && n == 40) rx_hold_req = HOLD_CYCLES;
                if (ph == 1 && n == 44) begin
                    s_tvalid = 1'b0;
                    wait_drained();
                end
                send_level(random_level(), 0, 0);
            end
        end

        s_tvalid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_segs.size() != 0) mismatch_cnt++;
        $display("%0d level transfers, %0d segment transfers checked, %0d register writes",
                 levels_sent, segs_checked, cfg_writes);
        $display("covered wake, hold, masked levels and four flow-control phases");
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/swde_pkg.sv
hdl/swde_seq.sv
hdl/single_wire_dimming_encoder.sv
tb/single_wire_dimming_encoder_tb.sv
